>>> design/bsh_pkg.sv
// ----------------------------------------------------------------------------
// Bit store with hash: shared package
// Command and result types, command codes and store constants.
// ----------------------------------------------------------------------------
`default_nettype none

package bsh_pkg;

	localparam int DEF_WORDS = 256;

	localparam logic [31:0] HASH_MUL_PLAIN  = 32'd731123123;
	localparam logic [31:0] HASH_MUL_SEEDED = 32'd1371121;

	localparam logic [13:0] BIT_COUNT_RESET = 14'd8192;

	localparam logic [2:0] MODE_CLEAR     = 3'd0;
	localparam logic [2:0] MODE_SET_FIELD = 3'd1;
	localparam logic [2:0] MODE_SET_ONES  = 3'd2;
	localparam logic [2:0] MODE_HASH      = 3'd3;
	localparam logic [2:0] MODE_HASH_SEED = 3'd4;
	localparam logic [2:0] MODE_LIST      = 3'd5;

	localparam logic REG_BIT_COUNT = 1'b0;

	typedef struct packed {
		logic [2:0]  mode;
		logic [30:0] data_value;
		logic [12:0] start_bit;
		logic [30:0] range_value;
		logic [30:0] hash_modulus;
		logic [7:0]  word_index;
	} cmd_t;

	typedef struct packed {
		logic [12:0] bit_index;
		logic [30:0] hash_value;
		logic        found;
		logic        is_last;
		logic        out_of_range;
	} res_t;

endpackage

`default_nettype wire

>>> design/bsh_cmd_if.sv
// ----------------------------------------------------------------------------
// Bit store with hash: command channel
// Valid/ready channel that carries one command request.
// ----------------------------------------------------------------------------
`default_nettype none

interface bsh_cmd_if;
	import bsh_pkg::*;
	logic valid;
	logic ready;
	cmd_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> design/bsh_res_if.sv
// ----------------------------------------------------------------------------
// Bit store with hash: result channel
// Valid/ready channel that carries one result.
// ----------------------------------------------------------------------------
`default_nettype none

interface bsh_res_if;
	import bsh_pkg::*;
	logic valid;
	logic ready;
	res_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> design/bitset_store_with_hash_top.sv
// Sequence: clear sweeps every word of the store, then issues; set modes read the first word,
// update it while reading the second, update the second, then issue; hashes make a first read,
// a multiply and an add per word in use and a 32-step modulo, then issue; list mode reads and
// checks the word, then issues one result per cycle for each set bit while the output is free.
// Register writes also sweep the store. One command at a time; the next is taken once the last
// result is registered. After reset a sweep clears the store; no command is taken during it.
// ----------------------------------------------------------------------------
// Bit store with hash: top level
// Store of 32-bit words in one synchronous memory with set, clear, hash and list commands.
// ----------------------------------------------------------------------------
`default_nettype none

module bitset_store_with_hash_top #(
	parameter int WORDS = bsh_pkg::DEF_WORDS
) (
	input  wire         clk,
	input  wire         arst_n,
	bsh_cmd_if.sink     cmd,
	bsh_res_if.source   res,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import bsh_pkg::*;

	localparam int AW  = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int CW  = $clog2(WORDS + 1);
	localparam int XW  = AW + 9;
	localparam int CAP = WORDS * 32;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_CLR  = 4'd1;
	localparam logic [3:0] ST_SET0 = 4'd2;
	localparam logic [3:0] ST_SET1 = 4'd3;
	localparam logic [3:0] ST_SET2 = 4'd4;
	localparam logic [3:0] ST_HRD  = 4'd5;
	localparam logic [3:0] ST_HMUL = 4'd6;
	localparam logic [3:0] ST_HADD = 4'd7;
	localparam logic [3:0] ST_DIV  = 4'd8;
	localparam logic [3:0] ST_LRD  = 4'd9;
	localparam logic [3:0] ST_LCHK = 4'd10;
	localparam logic [3:0] ST_LIST = 4'd11;
	localparam logic [3:0] ST_EMIT = 4'd12;

	logic [31:0] mem [WORDS];
	logic [31:0] rd_q;

	logic [3:0]  state_q;
	logic [13:0] bit_count_q;
	logic [CW-1:0] ctr_q;
	logic        clr_emit_q;
	cmd_t        item_q;
	logic [31:0] h_q;
	logic [31:0] mul_q;
	logic [31:0] prod_s1;
	logic [30:0] rem_q;
	logic [4:0]  div_cnt_q;
	logic [30:0] p_hash_q;
	logic        p_oor_q;
	logic [31:0] lw_q;
	logic        widx_ok_q;
	logic        res_valid_q;
	res_t        res_q;

	logic        we, re;
	logic [AW-1:0] waddr, raddr;
	logic [31:0] wdata;

	logic [13:0] eff;
	logic [9:0]  nwords;
	logic        out_free;
	logic        cfg_wr;
	logic        res_load;

	// set-mode masks
	logic [4:0]  len;
	logic [31:0] ones;
	logic [30:0] fbits;
	logic [62:0] shifted;
	logic signed [15:0] rem_bits;
	logic [62:0] inmask;
	logic [62:0] good;
	logic        oor;
	logic [XW-1:0] w0_x, w1_x, widx_x;

	logic [31:0] div_try;
	logic [31:0] low_bit;
	logic [4:0]  low_pos;
	logic [31:0] lw_rest;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign prdata   = (paddr[2] == REG_BIT_COUNT) ? {18'd0, bit_count_q} : 32'd0;
	assign out_free = !res_valid_q || res.ready;
	assign res_load = !(cfg_wr && paddr[2] == REG_BIT_COUNT) && out_free
		&& (state_q == ST_LIST || state_q == ST_EMIT);
	assign cmd.ready = (state_q == ST_IDLE);
	assign res.valid = res_valid_q;
	assign res.payload = res_q;

	assign eff    = (32'(bit_count_q) < CAP) ? bit_count_q : 14'(CAP);
	assign nwords = 10'((15'(eff) + 15'd31) >> 5);

	always_comb begin
		len = 5'd0;
		for (int i = 0; i < 31; i++) begin
			if (item_q.range_value[i]) len = 5'(i + 1);
		end
		ones     = (32'd1 << len) - 32'd1;
		fbits    = (item_q.mode == MODE_SET_ONES) ? ones[30:0] : (item_q.data_value & ones[30:0]);
		shifted  = 63'(fbits) << item_q.start_bit[4:0];
		rem_bits = 16'(eff) - 16'({item_q.start_bit[12:5], 5'd0});
		if (rem_bits <= 16'sd0)
			inmask = 63'd0;
		else if (rem_bits >= 16'sd63)
			inmask = {63{1'b1}};
		else
			inmask = (63'd1 << rem_bits[5:0]) - 63'd1;
		good   = shifted & inmask;
		oor    = |(shifted & ~inmask);
		w0_x   = XW'(item_q.start_bit[12:5]);
		w1_x   = XW'(item_q.start_bit[12:5]) + XW'(1);
		widx_x = XW'(item_q.word_index);
	end

	assign div_try = {rem_q, h_q[31]};

	always_comb begin
		low_bit = lw_q & (~lw_q + 32'd1);
		low_pos = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (low_bit[i]) low_pos = 5'(i);
		end
		lw_rest = lw_q & ~low_bit;
	end

	// Memory port control
	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		waddr = ctr_q[AW-1:0];
		raddr = ctr_q[AW-1:0];
		wdata = 32'd0;
		case (state_q)
			ST_CLR: begin
				we = 1'b1;
			end
			ST_SET0: begin
				re    = 1'b1;
				raddr = w0_x[AW-1:0];
			end
			ST_SET1: begin
				we    = |good[31:0];
				waddr = w0_x[AW-1:0];
				wdata = rd_q | good[31:0];
				re    = 1'b1;
				raddr = w1_x[AW-1:0];
			end
			ST_SET2: begin
				we    = |good[62:32];
				waddr = w1_x[AW-1:0];
				wdata = rd_q | {1'b0, good[62:32]};
			end
			ST_HRD, ST_HADD: begin
				re = 1'b1;
			end
			ST_LRD: begin
				re    = 1'b1;
				raddr = widx_x[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rd_q <= mem[raddr];
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd.valid) item_q <= cmd.payload;
		if (state_q == ST_HMUL) prod_s1 <= h_q * mul_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			bit_count_q <= BIT_COUNT_RESET;
			ctr_q       <= '0;
			clr_emit_q  <= 1'b0;
			h_q         <= 32'd0;
			mul_q       <= 32'd0;
			rem_q       <= 31'd0;
			div_cnt_q   <= 5'd0;
			p_hash_q    <= 31'd0;
			p_oor_q     <= 1'b0;
			lw_q        <= 32'd0;
			widx_ok_q   <= 1'b0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (res_load) res_valid_q <= 1'b1;
			else if (res.ready) res_valid_q <= 1'b0;
			if (cfg_wr && paddr[2] == REG_BIT_COUNT) begin
				bit_count_q <= pwdata[13:0];
				state_q     <= ST_CLR;
				ctr_q       <= '0;
				clr_emit_q  <= 1'b0;
			end else begin
				case (state_q)
					ST_IDLE: begin
						if (cmd.valid) begin
							p_hash_q <= 31'd0;
							p_oor_q  <= 1'b0;
							ctr_q    <= '0;
							case (cmd.payload.mode)
								MODE_CLEAR: begin
									clr_emit_q <= 1'b1;
									state_q    <= ST_CLR;
								end
								MODE_SET_FIELD, MODE_SET_ONES: state_q <= ST_SET0;
								MODE_HASH: begin
									h_q     <= 32'd0;
									mul_q   <= HASH_MUL_PLAIN;
									state_q <= ST_HRD;
								end
								MODE_HASH_SEED: begin
									h_q     <= {1'b0, cmd.payload.data_value};
									mul_q   <= HASH_MUL_SEEDED;
									state_q <= ST_HRD;
								end
								MODE_LIST: state_q <= ST_LRD;
								default: state_q <= ST_EMIT;
							endcase
						end
					end
					ST_CLR: begin
						ctr_q <= ctr_q + CW'(1);
						if (ctr_q == CW'(WORDS - 1))
							state_q <= clr_emit_q ? ST_EMIT : ST_IDLE;
					end
					ST_SET0: state_q <= ST_SET1;
					ST_SET1: state_q <= ST_SET2;
					ST_SET2: begin
						p_oor_q <= oor;
						state_q <= ST_EMIT;
					end
					ST_HRD: begin
						if (nwords == 10'd0) begin
							state_q   <= ST_DIV;
							rem_q     <= 31'd0;
							div_cnt_q <= 5'd0;
						end else begin
							ctr_q   <= ctr_q + CW'(1);
							state_q <= ST_HMUL;
						end
					end
					ST_HMUL: state_q <= ST_HADD;
					ST_HADD: begin
						h_q <= prod_s1 + rd_q;
						if (32'(ctr_q) == 32'(nwords)) begin
							state_q   <= ST_DIV;
							rem_q     <= 31'd0;
							div_cnt_q <= 5'd0;
						end else begin
							ctr_q   <= ctr_q + CW'(1);
							state_q <= ST_HMUL;
						end
					end
					ST_DIV: begin
						// Restoring division, one quotient bit per cycle.
						if (div_try >= {1'b0, item_q.hash_modulus})
							rem_q <= 31'(div_try - {1'b0, item_q.hash_modulus});
						else
							rem_q <= div_try[30:0];
						h_q       <= {h_q[30:0], 1'b0};
						div_cnt_q <= div_cnt_q + 5'd1;
						if (div_cnt_q == 5'd31) state_q <= ST_EMIT;
					end
					ST_LRD: begin
						widx_ok_q <= 10'(item_q.word_index) < nwords;
						state_q   <= ST_LCHK;
					end
					ST_LCHK: begin
						lw_q    <= widx_ok_q ? rd_q : 32'd0;
						state_q <= (widx_ok_q && rd_q != 32'd0) ? ST_LIST : ST_EMIT;
					end
					ST_LIST: begin
						if (out_free) begin
							res_q.bit_index    <= {item_q.word_index, low_pos};
							res_q.hash_value   <= 31'd0;
							res_q.found        <= 1'b1;
							res_q.is_last      <= (lw_rest == 32'd0);
							res_q.out_of_range <= 1'b0;
							lw_q               <= lw_rest;
							if (lw_rest == 32'd0) state_q <= ST_IDLE;
						end
					end
					ST_EMIT: begin
						if (out_free) begin
							res_q.bit_index    <= 13'd0;
							res_q.found        <= 1'b0;
							res_q.is_last      <= 1'b1;
							res_q.out_of_range <= p_oor_q;
							if ((item_q.mode == MODE_HASH || item_q.mode == MODE_HASH_SEED)
								&& item_q.hash_modulus != 31'd0)
								res_q.hash_value <= rem_q;
							else
								res_q.hash_value <= p_hash_q;
							clr_emit_q <= 1'b0;
							state_q    <= ST_IDLE;
						end
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

>>> sim/bitset_store_with_hash_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit store with hash: regression bench
// Drives set, clear, hash and list requests with random gaps on both channels,
// predicts every result from a local copy of the store and compares each field.
// ----------------------------------------------------------------------------

module bitset_store_with_hash_top_tb;
	import bsh_pkg::*;

	localparam int N_WORDS = DEF_WORDS;
	localparam int STALL_LIMIT = 20000;

	// Predicts results from its own copy of the store and checks arrivals in order.
	class store_scoreboard;
		logic [31:0] words [N_WORDS];
		int unsigned bit_limit;
		res_t pending [$];
		int mismatches;
		int results_seen;

		function new();
			bit_limit = 8192;
			mismatches = 0;
			results_seen = 0;
			wipe();
		endfunction

		function void wipe();
			for (int i = 0; i < N_WORDS; i++)
				words[i] = '0;
		endfunction

		function void queue_result(res_t r);
			pending.insert(pending.size(), r);
		endfunction

		function void set_bit_count(logic [13:0] v);
			bit_limit = (v > N_WORDS * 32) ? N_WORDS * 32 : v;
			wipe();
		endfunction

		function int unsigned used_words();
			return (bit_limit + 31) / 32;
		endfunction

		function logic [31:0] fold_store(logic [31:0] seed, logic [31:0] mul);
			logic [31:0] h;
			h = seed;
			for (int i = 0; i < used_words(); i++)
				h = mul * h + words[i];
			return h;
		endfunction

		function void note_request(cmd_t c);
			res_t r;
			int len;
			int unsigned p;
			logic [31:0] h;
			logic [31:0] w;
			r = '0;
			r.is_last = 1'b1;
			case (c.mode)
				MODE_CLEAR: begin
					wipe();
					queue_result(r);
				end
				MODE_SET_FIELD, MODE_SET_ONES: begin
					len = 0;
					for (int k = 0; k < 31; k++)
						if (c.range_value[k]) len = k + 1;
					for (int k = 0; k < len; k++) begin
						if (c.mode == MODE_SET_ONES || c.data_value[k]) begin
							p = c.start_bit + k;
							if (p >= bit_limit) r.out_of_range = 1'b1;
							else words[p / 32][p % 32] = 1'b1;
						end
					end
					queue_result(r);
				end
				MODE_HASH, MODE_HASH_SEED: begin
					if (c.mode == MODE_HASH) h = fold_store(32'd0, HASH_MUL_PLAIN);
					else h = fold_store({1'b0, c.data_value}, HASH_MUL_SEEDED);
					r.hash_value = (c.hash_modulus != 0) ? 31'(h % c.hash_modulus) : '0;
					queue_result(r);
				end
				MODE_LIST: begin
					w = (c.word_index < used_words()) ? words[c.word_index] : '0;
					if (w == 0) begin
						queue_result(r);
					end else begin
						for (int k = 0; k < 32; k++) begin
							if (w[k]) begin
								r.bit_index = 13'(c.word_index * 32 + k);
								r.found = 1'b1;
								r.is_last = ((w >> k) >> 1) == 0;
								queue_result(r);
							end
						end
					end
				end
				default: queue_result(r);
			endcase
		endfunction

		function void check_result(res_t got);
			res_t want;
			results_seen++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result mismatch: expected %p, got %p", want, got);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	bsh_cmd_if cmd_ch();
	bsh_res_if res_ch();

	bitset_store_with_hash_top dut (
		.clk(clk), .arst_n(arst_n), .cmd(cmd_ch.sink), .res(res_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	store_scoreboard sb;
	int idle_pct;
	bit hold_off;
	int quiet_cycles;
	int requests_sent;

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: random stalls, plus a long hold-off requested by the stimulus.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready)
				sb.check_result(res_ch.payload);
			res_ch.ready <= !hold_off && ($urandom_range(99) >= idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("bitset_store_with_hash_top regression: fail");
			$finish;
		end
	end

	task automatic apb_write(logic [13:0] v);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= 3'd0; pwdata <= {18'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		sb.set_bit_count(v);
	endtask

	// Valid stays high after acceptance until the next request or an idle cycle replaces it,
	// so that it is driven only once per clock edge.
	task automatic send(cmd_t c);
		while ($urandom_range(99) < idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.payload <= c;
		do @(posedge clk); while (!cmd_ch.ready);
		sb.note_request(c);
		requests_sent++;
	endtask

	task automatic drain();
		cmd_ch.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (2 * N_WORDS + 50) @(posedge clk);
	endtask

	function automatic cmd_t make(logic [2:0] m, logic [30:0] d, logic [12:0] s,
			logic [30:0] r, logic [30:0] md, logic [7:0] w);
		cmd_t c;
		c.mode = m; c.data_value = d; c.start_bit = s;
		c.range_value = r; c.hash_modulus = md; c.word_index = w;
		return c;
	endfunction

	function automatic cmd_t random_cmd(int unsigned bits);
		cmd_t c;
		int unsigned hi;
		hi = (bits == 0) ? 0 : bits - 1;
		c.data_value = 31'($urandom);
		c.range_value = 31'($urandom >> $urandom_range(31));
		c.hash_modulus = ($urandom_range(3) == 0) ? 31'($urandom_range(1000) + 1)
			: 31'($urandom);
		if ($urandom_range(9) == 0) c.hash_modulus = 31'h7fffffff;
		c.start_bit = ($urandom_range(9) == 0) ? 13'($urandom) : 13'($urandom_range(hi));
		c.word_index = ($urandom_range(9) == 0) ? 8'($urandom) : 8'(c.start_bit / 32);
		case ($urandom_range(99)) inside
			[0:1]: c.mode = MODE_CLEAR;
			[2:36]: c.mode = MODE_SET_FIELD;
			[37:49]: c.mode = MODE_SET_ONES;
			[50:59]: c.mode = MODE_HASH;
			[60:69]: c.mode = MODE_HASH_SEED;
			[70:97]: c.mode = MODE_LIST;
			default: c.mode = 3'($urandom_range(7, 6));
		endcase
		return c;
	endfunction

	task automatic random_phase(int n, int unsigned bits);
		for (int i = 0; i < n; i++) begin
			idle_pct = (i >= n / 3 && i < n / 2) ? 0 : 37;
			send(random_cmd(bits));
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		cmd_ch.valid = 1'b0; cmd_ch.payload = '0;
		idle_pct = 37; hold_off = 1'b0; quiet_cycles = 0; requests_sent = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: field extremes, each mode, out-of-range writes and odd modes.
		send(make(MODE_SET_ONES, 31'd0, 13'd0, 31'h7fffffff, 31'd1, 8'd0));
		send(make(MODE_SET_FIELD, 31'h7fffffff, 13'd8190, 31'h7fffffff, 31'd1, 8'd0));
		send(make(MODE_SET_FIELD, 31'h55555555, 13'd100, 31'd1, 31'd1, 8'd0));
		send(make(MODE_SET_FIELD, 31'd0, 13'd200, 31'd0, 31'd1, 8'd0));
		send(make(MODE_LIST, 31'd0, 13'd0, 31'd0, 31'd1, 8'd0));
		send(make(MODE_LIST, 31'd0, 13'd0, 31'd0, 31'd1, 8'd255));
		send(make(MODE_LIST, 31'd0, 13'd0, 31'd0, 31'd1, 8'd7));
		send(make(MODE_HASH, 31'd0, 13'd0, 31'd0, 31'h7fffffff, 8'd0));
		send(make(MODE_HASH, 31'd0, 13'd0, 31'd0, 31'd1, 8'd0));
		send(make(MODE_HASH_SEED, 31'h7fffffff, 13'd0, 31'd0, 31'd12345, 8'd0));
		send(make(MODE_HASH_SEED, 31'd0, 13'd0, 31'd0, 31'h7fffffff, 8'd0));
		send(make(3'd6, 31'h7fffffff, 13'h1fff, 31'h7fffffff, 31'h7fffffff, 8'hff));
		send(make(3'd7, 31'd0, 13'd0, 31'd0, 31'd0, 8'd0));
		send(make(MODE_CLEAR, 31'd0, 13'd0, 31'd0, 31'd1, 8'd0));
		send(make(MODE_LIST, 31'd0, 13'd0, 31'd0, 31'd1, 8'd0));
		send(make(MODE_HASH, 31'd0, 13'd0, 31'd0, 31'd97, 8'd0));

		// Long receiver hold-off while full words are listed.
		send(make(MODE_SET_ONES, 31'd0, 13'd64, 31'h7fffffff, 31'd1, 8'd0));
		send(make(MODE_SET_ONES, 31'd0, 13'd95, 31'd1, 31'd1, 8'd0));
		hold_off = 1'b1;
		fork
			begin
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
			end
			begin
				send(make(MODE_LIST, 31'd0, 13'd0, 31'd0, 31'd1, 8'd2));
				send(make(MODE_LIST, 31'd0, 13'd0, 31'd0, 31'd1, 8'd2));
				send(make(MODE_HASH, 31'd0, 13'd0, 31'd0, 31'd1000, 8'd0));
			end
		join
		drain();

		random_phase(120, 8192);
		drain();
		apb_write(14'd0);
		send(make(MODE_SET_ONES, 31'd0, 13'd0, 31'd3, 31'd1, 8'd0));
		send(make(MODE_HASH_SEED, 31'd77, 13'd0, 31'd0, 31'd1000, 8'd0));
		send(make(MODE_LIST, 31'd0, 13'd0, 31'd0, 31'd1, 8'd0));
		drain();
		apb_write(14'd37);
		random_phase(60, 37);
		drain();
		apb_write(14'h3fff);
		random_phase(50, 8192);
		drain();
		apb_write(14'd1);
		random_phase(20, 1);
		drain();
		apb_write(14'd8192);
		random_phase(10, 8192);
		drain();

		$display("Sent %0d requests over bit counts 8192, 0, 37, 16383, 1; checked %0d results.",
			requests_sent, sb.results_seen);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("bitset_store_with_hash_top regression: pass");
		else
			$display("bitset_store_with_hash_top regression: fail");
		$finish;
	end

endmodule
